// File: rtl/core/assert_macros.svh
// assertion macros used by circular_fifo_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_AT(lbl, i_clk, i_rst_n, prop, msg)

`endif

// File: rtl/core/cfq_pkg.sv
// types and codes of the circular fifo queue
`timescale 1ns / 1ps

package cfq_pkg;

    localparam int ACTION_W   = 2;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = 5;

    localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_ROTATE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [WORD_W-1:0]   data_in;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]   data_out;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_count;
        logic                is_empty;
        logic                is_full;
    } t_rsp;

endpackage

// File: rtl/core/cfq_req_if.sv
// request channel of the circular fifo queue
`timescale 1ns / 1ps

interface cfq_req_if;
    import cfq_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/cfq_rsp_if.sv
// result channel of the circular fifo queue
`timescale 1ns / 1ps

interface cfq_rsp_if;
    import cfq_pkg::*;

    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/core/cfq_store.sv
// word storage of the queue: one write port, one registered read port
`timescale 1ns / 1ps

module cfq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic [DATA_WIDTH-1:0]        o_rd_data,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  logic [DATA_WIDTH-1:0]        i_wr_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/circular_fifo_queue.sv
// top level of the circular fifo queue
//
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+-------------
//  i_req    | in  | action, data_in                                 | valid/ready
//  o_rsp    | out | data_out, status, fill_count, is_empty, is_full | valid/ready
//
// each request is accepted in the idle state, which reads the front word from the
// storage; the execute state then writes back and loads the result register
// a new request is taken while the previous result still waits in that register
// the execute state holds while the result register is full and not taken
// reset clears head and count, sets tail to the last slot; storage is not cleared
`timescale 1ns / 1ps

`include "assert_macros.svh"

module circular_fifo_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cfq_req_if.sink         i_req,
    cfq_rsp_if.source       o_rsp
);
    import cfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                  r_state, n_state;
    t_req                  r_req;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [CW-1:0]         r_count, n_count;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out;

    logic                  w_accept;
    logic                  w_done;
    logic [AW-1:0]         w_head_nx;
    logic [AW-1:0]         w_tail_nx;
    logic [DATA_WIDTH-1:0] w_rd_data;
    logic                  w_wr_en;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic [WORD_W-1:0]     w_dout;
    logic [STATUS_W-1:0]   w_status;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_done      = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    assign w_head_nx = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_tail_nx = (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;

    cfq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rd_en    (w_accept),
        .i_rd_addr  (r_head),
        .o_rd_data  (w_rd_data),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_tail_nx),
        .i_wr_data  (w_wr_data)
    );

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        w_wr_en   = 1'b0;
        w_wr_data = DATA_WIDTH'(r_req.data_in);
        w_dout    = '0;
        w_status  = ST_OK;
        priority if (r_req.action == ACT_PUSH) begin
            if (r_count == CW'(DEPTH)) begin
                w_status = ST_OVERFLOW;
            end else begin
                w_wr_en = w_done;
                n_tail  = w_tail_nx;
                n_count = r_count + 1'b1;
            end
        end else if (r_count == '0) begin
            w_status = ST_UNDERFLOW;
        end else if (r_req.action == ACT_POP) begin
            w_dout  = WORD_W'(w_rd_data);
            n_head  = w_head_nx;
            n_count = r_count - 1'b1;
        end else if (r_req.action == ACT_PEEK) begin
            w_dout = WORD_W'(w_rd_data);
        end else begin
            // rotate: front word goes to the slot after the rear, single word stays put
            if (r_count > CW'(1)) begin
                w_wr_en   = w_done;
                w_wr_data = w_rd_data;
                n_head    = w_head_nx;
                n_tail    = w_tail_nx;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_done) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= AW'(DEPTH - 1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_done) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req.payload;
        end
        if (w_done) begin
            r_out.data_out   <= w_dout;
            r_out.status     <= w_status;
            r_out.fill_count <= FILL_W'(n_count);
            r_out.is_empty   <= (n_count == '0);
            r_out.is_full    <= (n_count == CW'(DEPTH));
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    `ASSERT_CLK(a_count_bound, r_count <= CW'(DEPTH), "fill count beyond depth")
    `ASSERT_CLK(a_overflow_full,
        o_rsp.valid && o_rsp.payload.status == ST_OVERFLOW |-> o_rsp.payload.is_full,
        "overflow reported while not full")
    `ASSERT_CLK(a_underflow_empty,
        o_rsp.valid && o_rsp.payload.status == ST_UNDERFLOW
            |-> o_rsp.payload.is_empty && o_rsp.payload.data_out == '0,
        "underflow result not empty")
    `ASSERT_CLK(a_count_step,
        w_done |=> r_count == $past(r_count) || r_count == $past(r_count) + 1'b1
            || r_count == $past(r_count) - 1'b1,
        "fill count moved by more than one")
    `ASSERT_CLK(a_result_held,
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.payload),
        "waiting result overwritten")

endmodule
